/* rtl/hsv_to_rgb_pixel_defines.svh */
// assertion macros for the hsv to rgb pixel converter
`ifndef HSV_TO_RGB_PIXEL_DEFINES_SVH
`define HSV_TO_RGB_PIXEL_DEFINES_SVH

`ifndef SYNTH
// check that is switched off while reset is low
`define HSVRGB_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hsv_to_rgb_pixel check failed");
// check that also holds across reset
`define HSVRGB_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("hsv_to_rgb_pixel reset check failed");
`else
`define HSVRGB_ASSERT(name, prop)
`define HSVRGB_ASSERT_ALWAYS(name, prop)
`endif

`endif

/* rtl/hsvrgb_pkg.sv */
// shared constants and types of the hsv to rgb pixel converter
package hsvrgb_pkg;

  localparam int unsigned NumStages   = 5;
  localparam int unsigned HueW        = 16;
  localparam int unsigned ChanW       = 8;
  localparam int unsigned FracW       = 10;
  localparam int unsigned QuotW       = 7;

  // hue / 960 as (hue * HueRecip) >> HueShift, exact over 16-bit hue
  localparam int unsigned HueRecip    = 69906;
  localparam int unsigned HueShift    = 26;
  localparam int unsigned SectorSize  = 960;
  // q / 6 as (q * 43) >> 8, exact for q below 69
  localparam int unsigned Div6Recip   = 43;
  localparam int unsigned SectorCount = 6;
  // round(n / 960) = floor(floor((n + 480) / 64) / 15), /15 as (y * 4370) >> 16
  localparam int unsigned XRound      = 480;
  localparam int unsigned Div15Recip  = 4370;
  localparam int unsigned ChromaRound = 128;

  typedef logic [NumStages-1:0] stage_vec_t;
  typedef logic [ChanW-1:0]     chan_t;
  typedef logic [FracW-1:0]     frac_t;

  typedef enum logic [2:0] {
    SecRedYellow   = 3'd0,
    SecYellowGreen = 3'd1,
    SecGreenCyan   = 3'd2,
    SecCyanBlue    = 3'd3,
    SecBlueMagenta = 3'd4,
    SecMagentaRed  = 3'd5
  } sector_e;

endpackage

/* rtl/hsvrgb_hue.sv */
// hue path: sector index and distance term for the secondary component
module hsvrgb_hue (
  input  logic                       clk_i,
  input  logic [hsvrgb_pkg::HueW-1:0] hue_i,
  input  hsvrgb_pkg::stage_vec_t     en_i,
  output hsvrgb_pkg::sector_e        sector_o,
  output hsvrgb_pkg::frac_t          dist_o
);
  import hsvrgb_pkg::*;

  logic [QuotW-1:0] quot_q, quot_d;
  logic [HueW-1:0]  hue_q;
  logic [32:0]      hue_mul;
  logic [15:0]      quot_off;
  logic [15:0]      frac_full;
  logic [11:0]      quot_div6;
  logic [QuotW-1:0] sec_full;
  frac_t            frac;
  sector_e          sector_d, sector_q;
  frac_t            dist_d, dist_q;

  assign hue_mul = 33'(hue_i) * 33'(HueRecip);
  assign quot_d  = hue_mul[HueShift +: QuotW];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      quot_q <= quot_d;
      hue_q  <= hue_i;
    end
  end

  always_comb begin
    quot_off  = 16'(quot_q) * 16'(SectorSize);
    frac_full = hue_q - quot_off;
    frac      = frac_full[FracW-1:0];
    quot_div6 = 12'(quot_q) * 12'(Div6Recip);
    sec_full  = quot_q - QuotW'(quot_div6[11:8]) * QuotW'(SectorCount);
    sector_d  = sector_e'(sec_full[2:0]);
    // odd sectors fall toward the next primary
    dist_d    = sec_full[0] ? (FracW'(SectorSize) - frac) : frac;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sector_q <= sector_d;
      dist_q   <= dist_d;
    end
  end

  assign sector_o = sector_q;
  assign dist_o   = dist_q;

endmodule

/* rtl/hsvrgb_chroma.sv */
// chroma path: product of value and saturation rounded back to eight bits
module hsvrgb_chroma (
  input  logic                   clk_i,
  input  hsvrgb_pkg::chan_t      saturation_i,
  input  hsvrgb_pkg::chan_t      brightness_i,
  input  hsvrgb_pkg::stage_vec_t en_i,
  output hsvrgb_pkg::chan_t      chroma_o,
  output hsvrgb_pkg::chan_t      bright_o
);
  import hsvrgb_pkg::*;

  logic [15:0] prod_q;
  chan_t       bright1_q, bright2_q;
  chan_t       chroma_q;
  logic [16:0] rnd;
  logic [16:0] rnd_sum;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q    <= 16'(saturation_i) * 16'(brightness_i);
      bright1_q <= brightness_i;
    end
  end

  // round(p / 255) as (t + (t >> 8)) >> 8 with t = p + 128
  always_comb begin
    rnd     = 17'(prod_q) + 17'(ChromaRound);
    rnd_sum = rnd + (rnd >> 8);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      chroma_q  <= rnd_sum[15:8];
      bright2_q <= bright1_q;
    end
  end

  assign chroma_o = chroma_q;
  assign bright_o = bright2_q;

endmodule

/* rtl/hsvrgb_mix.sv */
// secondary component, offset and six-sector channel placement
module hsvrgb_mix (
  input  logic                   clk_i,
  input  hsvrgb_pkg::sector_e    sector_i,
  input  hsvrgb_pkg::frac_t      dist_i,
  input  hsvrgb_pkg::chan_t      chroma_i,
  input  hsvrgb_pkg::chan_t      bright_i,
  input  hsvrgb_pkg::stage_vec_t en_i,
  output hsvrgb_pkg::chan_t      red_o,
  output hsvrgb_pkg::chan_t      green_o,
  output hsvrgb_pkg::chan_t      blue_o
);
  import hsvrgb_pkg::*;

  logic [17:0] xprod_q;
  chan_t       chroma3_q, chroma4_q;
  chan_t       offs3_q, offs4_q;
  sector_e     sector3_q, sector4_q;
  chan_t       xval_q;
  logic [17:0] x_sum;
  logic [24:0] x_mul;
  chan_t       red_d, green_d, blue_d;
  chan_t       red_q, green_q, blue_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      xprod_q   <= 18'(chroma_i) * 18'(dist_i);
      chroma3_q <= chroma_i;
      offs3_q   <= bright_i - chroma_i;
      sector3_q <= sector_i;
    end
  end

  always_comb begin
    x_sum = xprod_q + 18'(XRound);
    x_mul = 25'(x_sum[17:6]) * 25'(Div15Recip);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      xval_q    <= x_mul[23:16];
      chroma4_q <= chroma3_q;
      offs4_q   <= offs3_q;
      sector4_q <= sector3_q;
    end
  end

  always_comb begin
    red_d   = offs4_q;
    green_d = offs4_q;
    blue_d  = offs4_q;
    unique case (sector4_q)
      SecRedYellow: begin
        red_d   = chroma4_q + offs4_q;
        green_d = xval_q + offs4_q;
      end
      SecYellowGreen: begin
        red_d   = xval_q + offs4_q;
        green_d = chroma4_q + offs4_q;
      end
      SecGreenCyan: begin
        green_d = chroma4_q + offs4_q;
        blue_d  = xval_q + offs4_q;
      end
      SecCyanBlue: begin
        green_d = xval_q + offs4_q;
        blue_d  = chroma4_q + offs4_q;
      end
      SecBlueMagenta: begin
        red_d   = xval_q + offs4_q;
        blue_d  = chroma4_q + offs4_q;
      end
      default: begin
        red_d   = chroma4_q + offs4_q;
        blue_d  = xval_q + offs4_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

/* rtl/hsv_to_rgb_pixel.sv */
// top level: hsv to rgb pixel converter, five register stages
// throughput: one item per cycle while the output is not stalled, set by the five-stage pipeline
// each stage loads when it is empty or the stage after it moves on
// reset clears the stage valid bits only; data registers are not reset
`include "hsv_to_rgb_pixel_defines.svh"
module hsv_to_rgb_pixel (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // hue [15:0], saturation [23:16], brightness [31:24]
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // red [7:0], green [15:8], blue [23:16]
  output logic [23:0] m_axis_tdata
);
  import hsvrgb_pkg::*;

  stage_vec_t vld_q, vld_d;
  stage_vec_t stage_en;
  logic       chain_en;
  sector_e    sector;
  frac_t      hue_dist;
  chan_t      chroma, bright;
  chan_t      red, green, blue;

  // a stage may load when it is empty or its content moves on this cycle;
  // walked from the output backward so bubbles get squeezed out
  always_comb begin
    chain_en = m_axis_tready;
    for (int i = NumStages - 1; i >= 0; i--) begin
      stage_en[i] = !vld_q[i] || chain_en;
      chain_en    = stage_en[i];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (stage_en[0]) begin
      vld_d[0] = s_axis_tvalid;
    end
    for (int i = 1; i < NumStages; i++) begin
      if (stage_en[i]) begin
        vld_d[i] = vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = stage_en[0];
  assign m_axis_tvalid = vld_q[NumStages-1];
  assign m_axis_tdata  = {blue, green, red};

  // hue split into sector and fraction distance (stages 1, 2)
  hsvrgb_hue u_hue (
    .clk_i    (clk_i),
    .hue_i    (s_axis_tdata[15:0]),
    .en_i     (stage_en),
    .sector_o (sector),
    .dist_o   (hue_dist)
  );

  // chroma from value times saturation (stages 1, 2)
  hsvrgb_chroma u_chroma (
    .clk_i        (clk_i),
    .saturation_i (s_axis_tdata[23:16]),
    .brightness_i (s_axis_tdata[31:24]),
    .en_i         (stage_en),
    .chroma_o     (chroma),
    .bright_o     (bright)
  );

  // secondary component, offset add and channel placement (stages 3 to 5)
  hsvrgb_mix u_mix (
    .clk_i    (clk_i),
    .sector_i (sector),
    .dist_i   (hue_dist),
    .chroma_i (chroma),
    .bright_i (bright),
    .en_i     (stage_en),
    .red_o    (red),
    .green_o  (green),
    .blue_o   (blue)
  );

  // an empty output stage never blocks the input
  `HSVRGB_ASSERT(a_ready_when_out_empty, !m_axis_tvalid |-> s_axis_tready)
  // taking an item into a full pipeline needs the output to drain
  `HSVRGB_ASSERT(a_full_accept_drains, (s_axis_tvalid && s_axis_tready && (&vld_q)) |-> m_axis_tready)
  // output valid only comes from the stage before it
  `HSVRGB_ASSERT(a_out_from_prev_stage, $rose(m_axis_tvalid) |-> $past(vld_q[NumStages-2]))
  // nothing leaves the cycle after reset is held
  `HSVRGB_ASSERT_ALWAYS(a_reset_empties, !rst_ni |=> !m_axis_tvalid)

endmodule
